// ===== rtl/suol_pkg.sv =====
// ----------------------------------------------------------------------------
// suol_pkg: shared types and constants
// Widths, request structs, compare result and sequencer states for the
// sorted unique offset list.
// ----------------------------------------------------------------------------
package suol_pkg;

  localparam int MAX_ENTRIES = 64;
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int OFF_W       = 64;
  localparam int POS_W       = 6;
  localparam int UCNT_W      = 7;

  localparam logic [OFF_W-1:0] INVALID_OFFSET = '1;

  typedef struct packed {
    logic [OFF_W-1:0] offset;
    logic             last_in;
  } in_data_t;

  typedef struct packed {
    logic [OFF_W-1:0]  sorted_offset;
    logic [POS_W-1:0]  position;
    logic [UCNT_W-1:0] unique_count;
    logic              last_out;
    logic              empty_res;
    logic              overflowed;
  } out_data_t;

  typedef struct packed {
    logic gt_prev;
    logic lt_best;
    logic invalid;
  } cmp_res_t;

  typedef enum logic [4:0] {
    ST_LOAD = 5'b00001,
    ST_SCAN = 5'b00010,
    ST_RD   = 5'b00100,
    ST_LD   = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

endpackage

// ===== rtl/suol_store.sv =====
// ----------------------------------------------------------------------------
// suol_store: offset store
// One write port and one registered read port over the loaded offsets.
// ----------------------------------------------------------------------------
module suol_store (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [suol_pkg::IDX_W-1:0] wr_addr,
  input  logic [suol_pkg::OFF_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [suol_pkg::IDX_W-1:0] rd_addr,
  output logic [suol_pkg::OFF_W-1:0] rd_data
);
  import suol_pkg::*;

  logic [OFF_W-1:0] mem_r [MAX_ENTRIES];
  logic [OFF_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/suol_cmp.sv =====
// ----------------------------------------------------------------------------
// suol_cmp: shared offset comparator
// Compares one candidate against the last emitted value and the current
// best, and flags the invalid marker.
// ----------------------------------------------------------------------------
module suol_cmp (
  input  logic [suol_pkg::OFF_W-1:0] cand,
  input  logic [suol_pkg::OFF_W-1:0] prev,
  input  logic [suol_pkg::OFF_W-1:0] best,
  output suol_pkg::cmp_res_t         res
);
  import suol_pkg::*;

  assign res.gt_prev = (cand > prev);
  assign res.lt_best = (cand < best);
  assign res.invalid = (cand == INVALID_OFFSET);

endmodule

// ===== rtl/sorted_unique_offset_list.sv =====
// ----------------------------------------------------------------------------
// sorted_unique_offset_list: sort and deduplicate a list of offsets
//
// Input requests carry one 64-bit offset and a last flag; in_ready is high
// only while loading, one request per cycle. Up to MAX_ENTRIES offsets are
// stored, later ones are dropped and flagged as overflowed on every result.
// After the last request the sequencer makes U+1 selection passes over the
// N stored offsets (U unique valid values), using one shared comparator
// and one store read port: each pass picks the smallest valid offset above
// the previous pick into a result memory. Results then leave one at a time
// through the RD, LD and OUT states, waiting in OUT while out_ready is low;
// the output register holds a request until it is taken. An empty list
// gives one result with empty_res set. After the final result is taken the
// block loads again. Reset (rst_n low, synchronous) empties the list and
// drops any run in progress.
// ----------------------------------------------------------------------------
module sorted_unique_offset_list (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  suol_pkg::in_data_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output suol_pkg::out_data_t  out_data
);
  import suol_pkg::*;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] load_cnt_r, load_cnt_nxt;
  logic             ovf_r, ovf_nxt;
  logic [CNT_W-1:0] scan_idx_r, scan_idx_nxt;
  logic             rd_vld_r, rd_vld_nxt;
  logic [OFF_W-1:0] prev_r, prev_nxt;
  logic             have_prev_r, have_prev_nxt;
  logic [OFF_W-1:0] best_r, best_nxt;
  logic             have_best_r, have_best_nxt;
  logic [CNT_W-1:0] uniq_r, uniq_nxt;
  logic [CNT_W-1:0] emit_idx_r, emit_idx_nxt;
  out_data_t        out_data_r, out_data_nxt;

  logic [OFF_W-1:0] res_mem_r [MAX_ENTRIES];
  logic [OFF_W-1:0] res_rd_data_r;

  logic             st_wr_en;
  logic             st_rd_en;
  logic [OFF_W-1:0] st_rd_data;
  cmp_res_t         cmp_res;
  logic             take;
  logic             scan_done;
  logic             res_wr_en;
  logic             store_room;

  assign store_room = (load_cnt_r < CNT_W'(MAX_ENTRIES));
  assign st_wr_en   = (state_r == ST_LOAD) && in_valid && store_room;
  assign st_rd_en   = (state_r == ST_SCAN) && (scan_idx_r < load_cnt_r);
  assign scan_done  = (state_r == ST_SCAN) && (scan_idx_r == load_cnt_r) && !rd_vld_r;
  assign res_wr_en  = scan_done && have_best_r;

  suol_store u_store (
    .clk     (clk),
    .wr_en   (st_wr_en),
    .wr_addr (load_cnt_r[IDX_W-1:0]),
    .wr_data (in_data.offset),
    .rd_en   (st_rd_en),
    .rd_addr (scan_idx_r[IDX_W-1:0]),
    .rd_data (st_rd_data)
  );

  suol_cmp u_cmp (
    .cand (st_rd_data),
    .prev (prev_r),
    .best (best_r),
    .res  (cmp_res)
  );

  assign take = rd_vld_r && !cmp_res.invalid && (!have_prev_r || cmp_res.gt_prev) &&
                (!have_best_r || cmp_res.lt_best);

  // result memory
  always_ff @(posedge clk) begin
    if (res_wr_en) begin
      res_mem_r[uniq_r[IDX_W-1:0]] <= best_r;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_RD) begin
      res_rd_data_r <= res_mem_r[emit_idx_r[IDX_W-1:0]];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    load_cnt_nxt  = load_cnt_r;
    ovf_nxt       = ovf_r;
    scan_idx_nxt  = scan_idx_r;
    rd_vld_nxt    = 1'b0;
    prev_nxt      = prev_r;
    have_prev_nxt = have_prev_r;
    best_nxt      = best_r;
    have_best_nxt = have_best_r;
    uniq_nxt      = uniq_r;
    emit_idx_nxt  = emit_idx_r;
    out_data_nxt  = out_data_r;

    case (state_r)
      ST_LOAD: begin
        if (in_valid) begin
          if (store_room) begin
            load_cnt_nxt = load_cnt_r + CNT_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_data.last_in) begin
            scan_idx_nxt = '0;
            state_nxt    = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (st_rd_en) begin
          scan_idx_nxt = scan_idx_r + CNT_W'(1);
          rd_vld_nxt   = 1'b1;
        end
        if (take) begin
          best_nxt      = st_rd_data;
          have_best_nxt = 1'b1;
        end
        if (scan_done) begin
          if (have_best_r) begin
            uniq_nxt      = uniq_r + CNT_W'(1);
            prev_nxt      = best_r;
            have_prev_nxt = 1'b1;
            have_best_nxt = 1'b0;
            scan_idx_nxt  = '0;
          end else if (uniq_r == '0) begin
            // nothing valid left
            out_data_nxt            = '0;
            out_data_nxt.last_out   = 1'b1;
            out_data_nxt.empty_res  = 1'b1;
            out_data_nxt.overflowed = ovf_r;
            state_nxt               = ST_OUT;
          end else begin
            emit_idx_nxt = '0;
            state_nxt    = ST_RD;
          end
        end
      end
      ST_RD: begin
        state_nxt = ST_LD;
      end
      ST_LD: begin
        out_data_nxt.sorted_offset = res_rd_data_r;
        out_data_nxt.position      = POS_W'(emit_idx_r);
        out_data_nxt.unique_count  = UCNT_W'(uniq_r);
        out_data_nxt.last_out      = ((emit_idx_r + CNT_W'(1)) == uniq_r);
        out_data_nxt.empty_res     = 1'b0;
        out_data_nxt.overflowed    = ovf_r;
        state_nxt                  = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready) begin
          if (out_data_r.last_out) begin
            load_cnt_nxt  = '0;
            ovf_nxt       = 1'b0;
            uniq_nxt      = '0;
            have_prev_nxt = 1'b0;
            have_best_nxt = 1'b0;
            scan_idx_nxt  = '0;
            state_nxt     = ST_LOAD;
          end else begin
            emit_idx_nxt = emit_idx_r + CNT_W'(1);
            state_nxt    = ST_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      load_cnt_r  <= '0;
      ovf_r       <= 1'b0;
      scan_idx_r  <= '0;
      rd_vld_r    <= 1'b0;
      have_prev_r <= 1'b0;
      have_best_r <= 1'b0;
      uniq_r      <= '0;
      emit_idx_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      load_cnt_r  <= load_cnt_nxt;
      ovf_r       <= ovf_nxt;
      scan_idx_r  <= scan_idx_nxt;
      rd_vld_r    <= rd_vld_nxt;
      have_prev_r <= have_prev_nxt;
      have_best_r <= have_best_nxt;
      uniq_r      <= uniq_nxt;
      emit_idx_r  <= emit_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prev_r     <= prev_nxt;
    best_r     <= best_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_ready  = (state_r == ST_LOAD);
  assign out_valid = (state_r == ST_OUT);
  assign out_data  = out_data_r;

endmodule

// ===== rtl/suol_chk.sv =====
// ----------------------------------------------------------------------------
// suol_chk: port checker
// Watches the request channels of the sorted unique offset list.
// ----------------------------------------------------------------------------
module suol_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input suol_pkg::out_data_t out_data
);
  import suol_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // loading and result delivery never overlap
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while a result is pending");

  a_empty_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.empty_res |->
      out_data.last_out && (out_data.sorted_offset == '0) &&
      (out_data.unique_count == '0) && (out_data.position == '0))
    else $error("empty result with nonzero fields");

  a_position: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.empty_res |->
      (UCNT_W'(out_data.position) < out_data.unique_count) &&
      (out_data.last_out == ((UCNT_W'(out_data.position) + UCNT_W'(1)) ==
                             out_data.unique_count)))
    else $error("position out of range or last flag wrong");

  // a new list may start right after the final result
  a_reload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_data.last_out |=> in_ready && !out_valid)
    else $error("block not ready after final result");

endmodule

bind sorted_unique_offset_list suol_chk u_suol_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
